// ===== sv/alsd_pkg.sv =====
// Shared definitions for the addressable LED strip driver.
// Opcodes, configuration register indexes, reset values and parameter defaults.
// No dependencies.
package alsd_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [2:0] cfg_index_t;

    localparam opcode_t OP_SET_ONE = 2'd0;
    localparam opcode_t OP_SET_ALL = 2'd1;
    localparam opcode_t OP_TICK    = 2'd2;

    localparam cfg_index_t REG_STRIP_LENGTH  = 3'd0;
    localparam cfg_index_t REG_ONE_DUTY      = 3'd1;
    localparam cfg_index_t REG_ZERO_DUTY     = 3'd2;
    localparam cfg_index_t REG_WHITE_ENABLE  = 3'd3;
    localparam cfg_index_t REG_RESET_PERIODS = 3'd4;

    localparam logic [7:0]  STRIP_LENGTH_RST  = 8'd1;
    localparam logic [15:0] RESET_PERIODS_RST = 16'd50;

    localparam int MAX_LEDS_DEF   = 256;
    localparam int DUTY_WIDTH_DEF = 16;

endpackage

// ===== sv/addressable_led_strip_driver.sv =====
// Addressable LED strip driver: color store plus bit-serial PWM compare encoder.
// A tick's result is registered, shown in the cycle after acceptance; a tick
// starting an LED first reads the store (ST_LOAD). Set-one writes the store on accept;
// set-all then sweeps the active LEDs (ST_FILL). Reset: async, active low; a clearing
// pass (ST_CLEAR) then zeroes all MAX_LEDS entries. Config writes are taken; no item
// is taken in ST_CLEAR, ST_LOAD or ST_FILL; else one per cycle if the output is free.
module addressable_led_strip_driver
    import alsd_pkg::*;
#(
    parameter int MAX_LEDS   = alsd_pkg::MAX_LEDS_DEF,
    parameter int DUTY_WIDTH = alsd_pkg::DUTY_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  alsd_pkg::cfg_index_t  cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  alsd_pkg::opcode_t     opcode,
    input  logic [7:0]            led_index,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [7:0]            white,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           compare_value,
    output logic                  sending,
    output logic                  frame_done
);
    import alsd_pkg::*;

    localparam int AW      = MAX_LEDS > 1 ? $clog2(MAX_LEDS) : 1;
    localparam int LIM_CAP = MAX_LEDS > 255 ? 255 : MAX_LEDS;
    localparam logic [15:0] DUTY_MASK =
        DUTY_WIDTH >= 16 ? 16'hFFFF : 16'((32'd1 << DUTY_WIDTH) - 32'd1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FILL  = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    // configuration
    logic [7:0]  strip_length_reg;
    logic [15:0] one_duty_reg;
    logic [15:0] zero_duty_reg;
    logic        white_enable_reg;
    logic [15:0] reset_periods_reg;

    // control and frame state
    logic [1:0]  ctl_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [7:0]  fill_cnt_reg;
    logic [31:0] fill_word_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [4:0]  bit_reg, bit_next;
    logic [15:0] gap_reg, gap_next;
    logic        pending_reg, pending_next;
    logic [31:0] shift_reg, shift_next;

    // result register
    logic        out_valid_reg;
    logic [15:0] cmp_reg, cmp_next;
    logic        snd_reg, snd_next;
    logic        done_reg, done_next;

    logic [7:0]  limit;
    logic [5:0]  nbits;
    logic [5:0]  bit_inc;
    logic [15:0] gap_inc;
    logic [31:0] in_word;
    logic [31:0] cur_word;
    logic        in_fire;
    logic        need_load;
    logic        tick_fire;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [31:0]   ram_rdata;

    assign limit   = (strip_length_reg < 8'(LIM_CAP)) ? strip_length_reg : 8'(LIM_CAP);
    assign nbits   = white_enable_reg ? 6'd32 : 6'd24;
    assign in_word = {green, red, blue, white};

    assign in_ready  = (ctl_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign need_load = (phase_reg == PH_DATA) && (pos_reg < limit) && (bit_reg == 5'd0);
    assign tick_fire = (in_fire && opcode == OP_TICK && !need_load) || (ctl_reg == ST_LOAD);
    assign cur_word  = (ctl_reg == ST_LOAD) ? ram_rdata : shift_reg;

    assign out_valid     = out_valid_reg;
    assign compare_value = cmp_reg;
    assign sending       = snd_reg;
    assign frame_done    = done_reg;

    // store write port: clearing pass, set-all sweep or single-LED write
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        unique case (ctl_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(fill_cnt_reg);
                ram_wdata = fill_word_reg;
            end
            ST_RUN:
            begin
                if (in_fire && opcode == OP_SET_ONE && led_index < limit)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(led_index);
                    ram_wdata = in_word;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ram_re = in_fire && opcode == OP_TICK && need_load;

    alsd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(pos_reg)),
        .rdata (ram_rdata)
    );

    // one bit period: emit the MSB of the shift word, then advance bit, LED or gap
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        bit_next     = bit_reg;
        gap_next     = gap_reg;
        pending_next = pending_reg;
        shift_next   = shift_reg;
        cmp_next     = '0;
        snd_next     = 1'b0;
        done_next    = 1'b0;
        bit_inc      = {1'b0, bit_reg} + 6'd1;
        gap_inc      = gap_reg + 16'd1;
        unique case (phase_reg)
            PH_DATA:
            begin
                snd_next = 1'b1;
                if (pos_reg < limit)
                begin
                    cmp_next   = (cur_word[31] ? one_duty_reg : zero_duty_reg) & DUTY_MASK;
                    shift_next = {cur_word[30:0], 1'b0};
                    if (bit_inc >= nbits)
                    begin
                        bit_next = '0;
                        pos_next = pos_reg + 8'd1;
                    end
                    else
                    begin
                        bit_next = bit_inc[4:0];
                    end
                end
                else if (bit_inc >= nbits)
                begin
                    bit_next   = '0;
                    gap_next   = '0;
                    phase_next = PH_GAP;
                end
                else
                begin
                    bit_next = bit_inc[4:0];
                end
            end
            PH_GAP:
            begin
                snd_next = 1'b1;
                gap_next = gap_inc;
                if (gap_inc >= reset_periods_reg)
                begin
                    done_next = 1'b1;
                    gap_next  = '0;
                    pos_next  = '0;
                    bit_next  = '0;
                    if (pending_reg)
                    begin
                        phase_next   = PH_DATA;
                        pending_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg  <= STRIP_LENGTH_RST;
            one_duty_reg      <= '0;
            zero_duty_reg     <= '0;
            white_enable_reg  <= 1'b0;
            reset_periods_reg <= RESET_PERIODS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STRIP_LENGTH:  strip_length_reg  <= cfg_data[7:0];
                REG_ONE_DUTY:      one_duty_reg      <= cfg_data;
                REG_ZERO_DUTY:     zero_duty_reg     <= cfg_data;
                REG_WHITE_ENABLE:  white_enable_reg  <= cfg_data[0];
                REG_RESET_PERIODS: reset_periods_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            fill_cnt_reg  <= '0;
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            bit_reg       <= '0;
            gap_reg       <= '0;
            pending_reg   <= 1'b0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_fire)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                bit_reg       <= bit_next;
                gap_reg       <= gap_next;
                pending_reg   <= pending_next;
                shift_reg     <= shift_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (ctl_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(MAX_LEDS - 1))
                    begin
                        ctl_reg <= ST_RUN;
                    end
                end
                ST_FILL:
                begin
                    fill_cnt_reg <= fill_cnt_reg + 8'd1;
                    if (fill_cnt_reg == limit - 8'd1)
                    begin
                        ctl_reg <= ST_RUN;
                    end
                end
                ST_LOAD:
                begin
                    ctl_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (in_fire && (opcode == OP_SET_ONE || opcode == OP_SET_ALL))
                    begin
                        // a write starts a frame when idle, else may mark a refresh
                        if (phase_reg == PH_IDLE)
                        begin
                            phase_reg   <= PH_DATA;
                            pos_reg     <= '0;
                            bit_reg     <= '0;
                            gap_reg     <= '0;
                            pending_reg <= 1'b0;
                        end
                        else if (opcode == OP_SET_ALL || led_index <= pos_reg)
                        begin
                            pending_reg <= 1'b1;
                        end
                        if (opcode == OP_SET_ALL && limit != 8'd0)
                        begin
                            fill_cnt_reg <= '0;
                            ctl_reg      <= ST_FILL;
                        end
                    end
                    else if (ram_re)
                    begin
                        ctl_reg <= ST_LOAD;
                    end
                end
                default:
                begin
                    ctl_reg <= ST_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_reg == ST_RUN && in_fire && opcode == OP_SET_ALL)
        begin
            fill_word_reg <= in_word;
        end
        if (tick_fire)
        begin
            cmp_reg  <= cmp_next;
            snd_reg  <= snd_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== sv/alsd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module alsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/alsd_check.sv =====
// Port-level assertions for the addressable LED strip driver, bound to the top level.
// Depends on alsd_pkg for the opcode codes.
module alsd_check (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input alsd_pkg::opcode_t    opcode,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [15:0]          compare_value,
    input logic                 sending,
    input logic                 frame_done
);
    import alsd_pkg::*;

    // frame end is reported only inside a frame
    a_done_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> sending)
        else $error("frame_done without sending");

    // idle periods and the frame-end item carry no duty
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!sending || frame_done) |-> compare_value == 16'd0)
        else $error("nonzero compare value outside data bits");

    // a new item on the output traces back to an accepted tick, directly or through the store read
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && in_ready && opcode == OP_TICK) ||
            $past(in_valid && in_ready && opcode == OP_TICK, 2))
        else $error("result without a tick");

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(compare_value))
        else $error("output item dropped or changed while stalled");

endmodule

bind addressable_led_strip_driver alsd_check u_alsd_check (.*);

// ===== dv/testbench.sv =====
// Testbench for the addressable LED strip driver: random and directed items over valid/ready,
// checked against an in-bench prediction of the PWM compare stream.
// Depends on alsd_pkg and addressable_led_strip_driver.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import alsd_pkg::*;

    localparam opcode_t     OP_UNUSED        = 2'd3;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT      = 3000;
    localparam int unsigned SETTLE_CYCLES    = MAX_LEDS_DEF + 24;
    localparam int unsigned REPORT_LIMIT     = 200;

    typedef struct packed {
        logic [15:0] compare_value;
        logic        sending;
        logic        frame_done;
    } pwm_result_t;

    class strip_scoreboard;
        typedef enum logic [1:0] {FRAME_IDLE, FRAME_DATA, FRAME_GAP} frame_phase_t;

        bit [31:0]    color_store [MAX_LEDS_DEF];
        frame_phase_t frame_phase;
        int unsigned  led_pos;
        int unsigned  bit_pos;
        bit [15:0]    gap_count;
        bit           refresh_pending;
        bit [31:0]    shift_word;

        bit [7:0]     strip_length;
        bit [15:0]    one_duty;
        bit [15:0]    zero_duty;
        bit           white_enable;
        bit [15:0]    reset_periods;

        pwm_result_t  expected_pwm [$];
        int unsigned  mismatches;

        function new();
            foreach (color_store[i]) color_store[i] = '0;
            frame_phase     = FRAME_IDLE;
            led_pos         = 0;
            bit_pos         = 0;
            gap_count       = '0;
            refresh_pending = 1'b0;
            shift_word      = '0;
            strip_length    = STRIP_LENGTH_RST;
            one_duty        = '0;
            zero_duty       = '0;
            white_enable    = 1'b0;
            reset_periods   = RESET_PERIODS_RST;
            mismatches      = 0;
        endfunction

        function void write_register(cfg_index_t idx, logic [15:0] data);
            case (idx)
                REG_STRIP_LENGTH:  strip_length  = data[7:0];
                REG_ONE_DUTY:      one_duty      = data;
                REG_ZERO_DUTY:     zero_duty     = data;
                REG_WHITE_ENABLE:  white_enable  = data[0];
                REG_RESET_PERIODS: reset_periods = data;
                default: ;
            endcase
        endfunction

        function void start_frame();
            frame_phase     = FRAME_DATA;
            led_pos         = 0;
            bit_pos         = 0;
            gap_count       = '0;
            refresh_pending = 1'b0;
        endfunction

        // Start a frame when idle, else flag a refresh if the LED is already sent or in flight.
        function void request_frame(int unsigned target);
            if (frame_phase == FRAME_IDLE)
                start_frame();
            else if (target <= led_pos)
                refresh_pending = 1'b1;
        endfunction

        function void accept_item(opcode_t op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                  logic [7:0] b, logic [7:0] w);
            bit [31:0]   word;
            int unsigned active;
            int unsigned led_bits;
            pwm_result_t res;
            word     = {g, r, b, w};
            active   = strip_length;
            led_bits = white_enable ? 32 : 24;
            res      = '0;
            case (op)
                OP_SET_ONE:
                begin
                    if (idx < active)
                        color_store[idx] = word;
                    request_frame(idx);
                end
                OP_SET_ALL:
                begin
                    for (int unsigned i = 0; i < active; i++)
                        color_store[i] = word;
                    request_frame(0);
                end
                OP_TICK:
                begin
                    if (frame_phase == FRAME_DATA) begin
                        res.sending = 1'b1;
                        if (led_pos < active) begin
                            if (bit_pos == 0)
                                shift_word = color_store[led_pos];
                            res.compare_value = shift_word[31] ? one_duty : zero_duty;
                            shift_word = shift_word << 1;
                            bit_pos++;
                            if (bit_pos >= led_bits) begin
                                bit_pos = 0;
                                led_pos++;
                            end
                        end else begin
                            // tail: one LED-width of zero periods
                            bit_pos++;
                            if (bit_pos >= led_bits) begin
                                bit_pos     = 0;
                                gap_count   = '0;
                                frame_phase = FRAME_GAP;
                            end
                        end
                    end else if (frame_phase == FRAME_GAP) begin
                        res.sending = 1'b1;
                        gap_count   = gap_count + 16'd1;
                        if (gap_count >= reset_periods) begin
                            res.frame_done = 1'b1;
                            gap_count      = '0;
                            if (refresh_pending) begin
                                start_frame();
                            end else begin
                                frame_phase = FRAME_IDLE;
                                led_pos     = 0;
                                bit_pos     = 0;
                            end
                        end
                    end
                    expected_pwm.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [15:0] cmp, logic snd, logic done);
            pwm_result_t want;
            if (expected_pwm.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result compare_value=%h sending=%b frame_done=%b",
                             $time, cmp, snd, done);
                return;
            end
            want = expected_pwm.pop_front();
            if (want.compare_value !== cmp || want.sending !== snd || want.frame_done !== done)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: mismatch expected compare_value=%h sending=%b frame_done=%b, %s",
                             $time, want.compare_value, want.sending, want.frame_done,
                             $sformatf("got compare_value=%h sending=%b frame_done=%b",
                                       cmp, snd, done));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    cfg_index_t  cfg_index = REG_STRIP_LENGTH;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    opcode_t     opcode = OP_TICK;
    logic [7:0]  led_index = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic [7:0]  white = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] compare_value;
    logic        sending;
    logic        frame_done;

    strip_scoreboard sb;
    bit              idle_on = 1'b0;
    bit              long_hold_request = 1'b0;
    int unsigned     stall_cycles = 0;

    addressable_led_strip_driver i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .led_index     (led_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .white         (white),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .compare_value (compare_value),
        .sending       (sending),
        .frame_done    (frame_done)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 8'h00;
        if (roll < 30)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Both handshakes are sampled here so prediction follows acceptance order.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.accept_item(opcode, led_index, red, green, blue, white);
        if (out_valid && out_ready)
            sb.check_result(compare_value, sending, frame_done);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls while idle_on is set, or one long hold on request.
    initial
    begin
        forever begin
            @(posedge clk);
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat (gap_length() + 1) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
    endtask

    task automatic configure(logic [7:0] len, logic [15:0] one, logic [15:0] zero,
                             logic white_on, logic [15:0] gap_ticks);
        write_reg(REG_STRIP_LENGTH, {8'd0, len});
        write_reg(REG_ONE_DUTY, one);
        write_reg(REG_ZERO_DUTY, zero);
        write_reg(REG_WHITE_ENABLE, {15'd0, white_on});
        write_reg(REG_RESET_PERIODS, gap_ticks);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(opcode_t op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [7:0] w);
        int unsigned gap;
        in_valid  <= 1'b1;
        opcode    <= op;
        led_index <= idx;
        red       <= r;
        green     <= g;
        blue      <= b;
        white     <= w;
        do @(posedge clk); while (!(in_valid && in_ready));
        if (idle_on) begin
            gap = gap_length();
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_random(int unsigned count);
        int unsigned sent;
        int unsigned roll;
        logic [7:0]  idx;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                idx = (sb.strip_length == 0) ? 8'd0 : 8'($urandom_range(0, sb.strip_length - 1));
            else
                idx = 8'($urandom);
            if (roll < 3) begin
                // noise: unused opcode, not counted
                send_item(OP_UNUSED, idx, pick_byte(), pick_byte(), pick_byte(), pick_byte());
                continue;
            end
            if (roll < 75)
                send_item(OP_TICK, idx, pick_byte(), pick_byte(), pick_byte(), pick_byte());
            else if (roll < 93)
                send_item(OP_SET_ONE, idx, pick_byte(), pick_byte(), pick_byte(), pick_byte());
            else
                send_item(OP_SET_ALL, idx, pick_byte(), pick_byte(), pick_byte(), pick_byte());
            sent++;
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_pwm.size() != 0);
    endtask

    // Let a trailing set-all walk finish before the registers change.
    task automatic drain();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle tick, unused opcode, out-of-range index, writes around the
        // LED being sent, set-all during a frame, one-tick reset gap
        configure(8'd2, 16'hFFFF, 16'h0001, 1'b1, 16'd0);
        send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_SET_ONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_SET_ONE, 8'h01, 8'hA5, 8'h5A, 8'hFF, 8'h00);
        repeat (4) send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_SET_ONE, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_item(OP_SET_ONE, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_item(OP_SET_ONE, 8'h02, 8'h12, 8'h34, 8'h56, 8'h78);
        repeat (3) send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_SET_ALL, 8'h80, 8'h01, 8'h80, 8'h7F, 8'hFE);
        repeat (4) send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        drain();

        idle_on = 1'b1;
        configure(8'd1, 16'h0000, 16'hFFFF, 1'b0, 16'd1);
        send_random(150);
        drain();

        // fill the block under a long receiver hold, then pause the sender
        configure(8'd3, 16'($urandom), 16'($urandom), 1'b1, 16'd4);
        send_random(80);
        long_hold_request = 1'b1;
        send_random(120);
        wait_for_results();
        send_random(60);
        drain();

        // zero-length strip: frames are only tail and gap
        configure(8'd0, 16'($urandom), 16'($urandom), 1'b0, 16'd2);
        send_random(100);
        drain();

        // longest strip and gap; the next phase shortens both mid-frame
        configure(8'd255, 16'($urandom), 16'h0000, 1'b1, 16'hFFFF);
        send_random(80);
        drain();

        idle_on = 1'b0;
        configure(8'd4, 16'h8000, 16'h7FFF, 1'b0, 16'd3);
        send_random(150);
        drain();

        for (int p = 0; p < 4; p++) begin
            idle_on = p[0];
            configure(8'($urandom_range(1, 6)), 16'($urandom), 16'($urandom),
                      1'($urandom_range(0, 1)), 16'($urandom_range(1, 12)));
            send_random(120);
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_pwm.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== addressable_led_strip_driver.f =====
sv/alsd_pkg.sv
sv/alsd_ram.sv
sv/addressable_led_strip_driver.sv
sv/alsd_check.sv
dv/testbench.sv
